FILE: hw/rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque with remove-by-value.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH_DEFAULT      = 32;
  localparam int CMDQ_DEPTH_DEFAULT = 2;

  localparam int VAL_W    = 32;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 6;

  // command selector codes on the input channel
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_LIST_FWD   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_LIST_BWD   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE     = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_LIST_FWD,
    OP_LIST_BWD,
    OP_REMOVE,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIST_RD,
    S_LIST_EMIT,
    S_REM_RD,
    S_REM_CHK,
    S_REM_DONE
  } st_t;

endpackage

FILE: hw/rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/bdq_front.sv
// ----------------------------------------------------------------------------
// bdq_front
// Input stage: takes command words, decodes the selector, drops unused codes.
// ----------------------------------------------------------------------------
module bdq_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [bdq_pkg::FUNC_W-1:0]             in_func,
  input  logic signed [bdq_pkg::VAL_W-1:0]       in_value,
  output logic                                   cmd_valid,
  input  logic                                   cmd_ready,
  output bdq_pkg::cmd_t                          cmd
);

  logic          fv_r, fv_nxt;
  bdq_pkg::cmd_t fcmd_r, fcmd_nxt;
  logic          known;
  bdq_pkg::op_t  op;

  always_comb begin
    known = 1'b1;
    op    = bdq_pkg::OP_PUSH_FRONT;
    unique case (in_func)
      bdq_pkg::FUNC_PUSH_FRONT: op = bdq_pkg::OP_PUSH_FRONT;
      bdq_pkg::FUNC_PUSH_BACK:  op = bdq_pkg::OP_PUSH_BACK;
      bdq_pkg::FUNC_LIST_FWD:   op = bdq_pkg::OP_LIST_FWD;
      bdq_pkg::FUNC_LIST_BWD:   op = bdq_pkg::OP_LIST_BWD;
      bdq_pkg::FUNC_REMOVE:     op = bdq_pkg::OP_REMOVE;
      bdq_pkg::FUNC_CLEAR:      op = bdq_pkg::OP_CLEAR;
      default:                  known = 1'b0;
    endcase
  end

  assign in_ready  = !fv_r || cmd_ready;
  assign cmd_valid = fv_r;
  assign cmd       = fcmd_r;

  always_comb begin
    fv_nxt   = fv_r && !cmd_ready;
    fcmd_nxt = fcmd_r;
    if (in_valid && in_ready) begin
      // unused selectors produce no result: never enter the queue
      fv_nxt         = known;
      fcmd_nxt.op    = op;
      fcmd_nxt.value = in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
    fcmd_r <= fcmd_nxt;
  end

endmodule

FILE: hw/rtl/bdq_cmdq.sv
// ----------------------------------------------------------------------------
// bdq_cmdq
// Small command FIFO between the decode stage and the execution engine.
// ----------------------------------------------------------------------------
module bdq_cmdq #(
  parameter int QDEPTH = bdq_pkg::CMDQ_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  bdq_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bdq_pkg::cmd_t pop_data
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  bdq_pkg::cmd_t slots_r [QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          do_push, do_pop;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign push_ready = (n_r != NW'(QDEPTH));
  assign pop_valid  = (n_r != '0);
  assign pop_data   = slots_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt = do_push ? wrap_inc(wp_r) : wp_r;
    rp_nxt = do_pop  ? wrap_inc(rp_r) : rp_r;
    n_nxt  = n_r;
    if (do_push && !do_pop) begin
      n_nxt = n_r + NW'(1);
    end else if (!do_push && do_pop) begin
      n_nxt = n_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r  <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      n_r  <= n_nxt;
    end
    if (do_push) begin
      slots_r[wp_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/bdq_back.sv
// ----------------------------------------------------------------------------
// bdq_back
// Execution engine: owns the circular store, runs pushes, clears, walks and removal,
// and drives the registered result port.
// ----------------------------------------------------------------------------
module bdq_back #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  bdq_pkg::cmd_t                       cmd,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bdq_pkg::VAL_W-1:0]    out_item_value,
  output logic [bdq_pkg::STATUS_W-1:0]        out_status,
  output logic [bdq_pkg::CNT_W-1:0]           out_removed_count,
  output logic [bdq_pkg::CNT_W-1:0]           out_occupancy,
  output logic                                out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int VW = bdq_pkg::VAL_W;
  localparam int OW = bdq_pkg::CNT_W;

  bdq_pkg::st_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  bdq_pkg::cmd_t cur_r, cur_nxt;

  logic                            ov_r, ov_nxt;
  logic signed [VW-1:0]            oitem_r, oitem_nxt;
  logic [bdq_pkg::STATUS_W-1:0]    ostat_r, ostat_nxt;
  logic [OW-1:0]                   orem_r, orem_nxt;
  logic [OW-1:0]                   oocc_r, oocc_nxt;
  logic                            olast_r, olast_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VW-1:0] ram_wdata, ram_rdata;

  logic          out_free, is_empty, is_full, walk, at_end;
  logic [CW-1:0] list_off, removed;

  // (h + off) mod DEPTH, with h < DEPTH and off <= DEPTH
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    slot = s[AW-1:0];
  endfunction

  bdq_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !ov_r || out_ready;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(DEPTH));
  // list/remove on a non-empty store walk the entries; all else answers at once
  assign walk     = !is_empty && (cmd.op == bdq_pkg::OP_LIST_FWD ||
                                  cmd.op == bdq_pkg::OP_LIST_BWD ||
                                  cmd.op == bdq_pkg::OP_REMOVE);
  assign at_end   = (idx_r == count_r - CW'(1));
  assign list_off = (cur_r.op == bdq_pkg::OP_LIST_FWD) ? idx_r
                                                       : count_r - CW'(1) - idx_r;
  assign removed  = count_r - kept_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        if (cmd_valid && walk) begin
          state_nxt = (cmd.op == bdq_pkg::OP_REMOVE) ? bdq_pkg::S_REM_RD
                                                     : bdq_pkg::S_LIST_RD;
        end
      end
      bdq_pkg::S_LIST_RD:   state_nxt = bdq_pkg::S_LIST_EMIT;
      bdq_pkg::S_LIST_EMIT: begin
        if (out_free) begin
          state_nxt = at_end ? bdq_pkg::S_IDLE : bdq_pkg::S_LIST_RD;
        end
      end
      bdq_pkg::S_REM_RD:    state_nxt = bdq_pkg::S_REM_CHK;
      bdq_pkg::S_REM_CHK:   state_nxt = at_end ? bdq_pkg::S_REM_DONE : bdq_pkg::S_REM_RD;
      bdq_pkg::S_REM_DONE: begin
        if (out_free) begin
          state_nxt = bdq_pkg::S_IDLE;
        end
      end
      default:              state_nxt = bdq_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_ready = 1'b0;
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    kept_nxt  = kept_r;
    cur_nxt   = cur_r;
    ram_we    = 1'b0;
    ram_waddr = slot(head_r, kept_r);
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = slot(head_r, idx_r);
    ov_nxt    = ov_r && !out_ready;
    oitem_nxt = oitem_r;
    ostat_nxt = ostat_r;
    orem_nxt  = orem_r;
    oocc_nxt  = oocc_r;
    olast_nxt = olast_r;

    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        if (cmd_valid && walk) begin
          cmd_ready = 1'b1;
          cur_nxt   = cmd;
          idx_nxt   = '0;
          kept_nxt  = '0;
        end else if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          ov_nxt    = 1'b1;
          oitem_nxt = '0;
          ostat_nxt = bdq_pkg::STAT_OK;
          orem_nxt  = '0;
          olast_nxt = 1'b1;
          case (cmd.op)
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                ostat_nxt = bdq_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = cmd.value;
                count_nxt = count_r + CW'(1);
                if (cmd.op == bdq_pkg::OP_PUSH_FRONT) begin
                  head_nxt  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
                  ram_waddr = head_nxt;
                end else begin
                  ram_waddr = slot(head_r, count_r);
                end
              end
            end
            bdq_pkg::OP_CLEAR: begin
              if (is_empty) begin
                ostat_nxt = bdq_pkg::STAT_EMPTY;
              end else begin
                count_nxt = '0;
                head_nxt  = '0;
              end
            end
            default: ostat_nxt = bdq_pkg::STAT_EMPTY;
          endcase
          oocc_nxt = OW'(count_nxt);
        end
      end
      bdq_pkg::S_LIST_RD: begin
        ram_re    = 1'b1;
        ram_raddr = slot(head_r, list_off);
      end
      bdq_pkg::S_LIST_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oitem_nxt = ram_rdata;
          ostat_nxt = bdq_pkg::STAT_OK;
          orem_nxt  = '0;
          oocc_nxt  = OW'(count_r);
          olast_nxt = at_end;
          idx_nxt   = idx_r + CW'(1);
        end
      end
      bdq_pkg::S_REM_RD: begin
        ram_re = 1'b1;
      end
      bdq_pkg::S_REM_CHK: begin
        // compact survivors toward the head; write slot never passes the read slot
        if (ram_rdata != cur_r.value) begin
          ram_we   = 1'b1;
          kept_nxt = kept_r + CW'(1);
        end
        idx_nxt = idx_r + CW'(1);
      end
      bdq_pkg::S_REM_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oitem_nxt = '0;
          ostat_nxt = (removed == '0) ? bdq_pkg::STAT_NOTFOUND : bdq_pkg::STAT_OK;
          orem_nxt  = OW'(removed);
          oocc_nxt  = OW'(kept_r);
          olast_nxt = 1'b1;
          count_nxt = kept_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r   <= idx_nxt;
    kept_r  <= kept_nxt;
    cur_r   <= cur_nxt;
    oitem_r <= oitem_nxt;
    ostat_r <= ostat_nxt;
    orem_r  <= orem_nxt;
    oocc_r  <= oocc_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid         = ov_r;
  assign out_item_value    = oitem_r;
  assign out_status        = ostat_r;
  assign out_removed_count = orem_r;
  assign out_occupancy     = oocc_r;
  assign out_last          = olast_r;

endmodule

FILE: hw/rtl/bounded_deque_remove_by_value.sv
// ----------------------------------------------------------------------------
// bounded_deque_remove_by_value
// Bounded double-ended list of signed words with push, list, remove and clear.
// ----------------------------------------------------------------------------
// Pushes and clears sustain one word per cycle unless the result port stalls; with
// the store's registered read port, listing takes a read and an emit state per
// entry, and removal a read and a check state per stored entry plus a done state.
// A 2-word command queue decouples decode from execution; no new command is taken
// during a walk. Reset empties the list and the queue; the store is not cleared.
module bounded_deque_remove_by_value #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
  parameter int CMDQ_DEPTH = bdq_pkg::CMDQ_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bdq_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [bdq_pkg::VAL_W-1:0]    in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bdq_pkg::VAL_W-1:0]    out_item_value,
  output logic [bdq_pkg::STATUS_W-1:0]        out_status,
  output logic [bdq_pkg::CNT_W-1:0]           out_removed_count,
  output logic [bdq_pkg::CNT_W-1:0]           out_occupancy,
  output logic                                out_last
);

  logic          f_valid, f_ready, q_valid, q_ready;
  bdq_pkg::cmd_t f_cmd, q_cmd;

  bdq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .in_value  (in_value),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  bdq_cmdq #(.QDEPTH(CMDQ_DEPTH)) u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  bdq_back #(.DEPTH(DEPTH)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (q_valid),
    .cmd_ready         (q_ready),
    .cmd               (q_cmd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item_value    (out_item_value),
    .out_status        (out_status),
    .out_removed_count (out_removed_count),
    .out_occupancy     (out_occupancy),
    .out_last          (out_last)
  );

endmodule

FILE: hw/rtl/bdq_checker.sv
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the result channel of the deque, bound to the top.
// ----------------------------------------------------------------------------
module bdq_checker #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [bdq_pkg::VAL_W-1:0]    out_item_value,
  input logic [bdq_pkg::STATUS_W-1:0]        out_status,
  input logic [bdq_pkg::CNT_W-1:0]           out_removed_count,
  input logic [bdq_pkg::CNT_W-1:0]           out_occupancy,
  input logic                                out_last
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_value) &&
    $stable(out_status) && $stable(out_removed_count) && $stable(out_occupancy) &&
    $stable(out_last))
    else $error("result word changed while stalled");

  // only listing gives more than one word, and those are plain ok rows
  a_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == bdq_pkg::STAT_OK && out_removed_count == '0)
    else $error("non-final word is not a listing row");

  // occupancy is constant across a listing
  a_list_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> $stable(out_occupancy))
    else $error("occupancy moved during a listing");

  // a dropped push reports a full store
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bdq_pkg::STAT_FULL |->
    out_occupancy == bdq_pkg::CNT_W'(DEPTH) && out_item_value == '0 && out_last)
    else $error("full status without a full store");

  // a removal result that removed entries carries no element and is the only word
  a_rem_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_removed_count != '0 |->
    out_item_value == '0 && out_status == bdq_pkg::STAT_OK && out_last)
    else $error("bad removal result");

endmodule

bind bounded_deque_remove_by_value bdq_checker #(
  .DEPTH (DEPTH)
) u_bdq_checker (.*);
